>>> hdl/sem_pkg.sv
// Shared constants and types for the Sobel edge magnitude block.
package sem_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int FW_W      = 11;
   localparam int FH_W      = 16;
   localparam int ROW_W     = FH_W + 1;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int LINE_W    = 2 * PIX_W;
   localparam int GRAD_W    = 11;
   localparam int SUM_W     = 21;
   localparam int STEP_W    = $clog2(CHAN_W);
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   typedef logic [PIX_W-1:0]  pixel_type;
   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic signed [GRAD_W-1:0] grad_type;
   typedef logic [SUM_W-1:0] sum_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   localparam logic MODE_PIXEL = 1'b0;

endpackage

>>> hdl/sem_ifs.sv
// Valid/ready stream interfaces for the pixel input and the edge result output.
interface sem_req_if;
   import sem_pkg::*;
   logic     valid;
   logic     ready;
   logic     mode;
   chan_type in_red;
   chan_type in_green;
   chan_type in_blue;
   modport source (output valid, mode, in_red, in_green, in_blue, input ready);
   modport sink (input valid, mode, in_red, in_green, in_blue, output ready);
endinterface

interface sem_rsp_if;
   import sem_pkg::*;
   logic     valid;
   logic     ready;
   chan_type edge_red;
   chan_type edge_green;
   chan_type edge_blue;
   logic     frame_end;
   modport source (output valid, edge_red, edge_green, edge_blue, frame_end, input ready);
   modport sink (input valid, edge_red, edge_green, edge_blue, frame_end, output ready);
endinterface

>>> hdl/sobel_edge_magnitude_rgb.sv
// Top level of the 3x3 Sobel edge magnitude block for RGB pixel streams.
// Pixels enter in raster order, one transfer per item, and the block works on one item at a
// time: an item that yields a result passes the line store read, the gradient and square stages
// and the eight-step root search (one result bit per cycle); a pixel that yields no result
// ends after the line store read; a drain tick in the pixel phase is dropped. Both line
// stores share one 48-bit RAM entry per column, read and written back once per item taken.
// The result for pixel (r,c) appears after pixel (r+1,c+1), or after (r+2,0) in the last
// column; after each frame send width+1 drain items (mode 1) to flush, and the last result
// carries frame_end. Line stores need no clearing after reset. Write registers only when idle.
module sobel_edge_magnitude_rgb (
   input  logic clock,
   input  logic reset,
   sem_req_if.sink   req_chan,
   sem_rsp_if.source rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [sem_pkg::ADDR_W-1:0] paddr,
   input  logic [sem_pkg::DATA_W-1:0] pwdata,
   output logic [sem_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import sem_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_GRAD, S_SQR, S_ROOT, S_OUT
   } state_type;

   state_type        state_ff;
   logic [FW_W-1:0]  fw;
   logic [FH_W-1:0]  fh;
   logic [FW_W-1:0]  w_eff;
   logic [FH_W-1:0]  h_eff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   pixel_type        px_ff;
   pixel_type        win_ff [9];
   logic             last_ff;
   logic             lz_ff;
   logic             rz_ff;
   grad_type         gx_ff [3];
   grad_type         gy_ff [3];
   grad_type         gx_in [3];
   grad_type         gy_in [3];
   sum_type          sum_in [3];
   logic [2:0]       root_done;
   chan_type         root_res [3];
   logic             rsp_valid_ff;
   chan_type         rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic             rsp_end_ff;

   logic             accept, drain, take, rsp_load;
   logic [LINE_W-1:0] rdata;
   pixel_type        top, mid;
   logic             opv, last;
   logic [ROW_W:0]   row_x, h_x;
   logic [FW_W-1:0]  col_next;

   sem_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .frame_width(fw), .frame_height(fh)
   );

   assign w_eff = (fw == '0) ? FW_W'(1) : ((fw > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw);
   assign h_eff = (fh == '0) ? FH_W'(1) : fh;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && req_chan.ready;
   assign drain  = row_ff >= ROW_W'(h_eff);
   assign take   = accept && (drain || req_chan.mode == MODE_PIXEL);

   sem_ram #(.WIDTH(LINE_W), .DEPTH(MAX_WIDTH)) u_lines (
      .clock,
      .we(state_ff == S_READ), .waddr(col_ff), .wdata({rdata[PIX_W-1:0], px_ff}),
      .re(take), .raddr(col_ff), .rdata
   );

   assign row_x = (ROW_W+1)'(row_ff);
   assign h_x   = (ROW_W+1)'(h_eff);
   assign top = (row_ff >= ROW_W'(2) && row_x < h_x + (ROW_W+1)'(2)) ?
                rdata[LINE_W-1:PIX_W] : '0;
   assign mid = (row_ff >= ROW_W'(1) && row_x < h_x + (ROW_W+1)'(1)) ?
                rdata[PIX_W-1:0] : '0;
   assign opv  = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
   assign last = row_x >= h_x + (ROW_W+1)'(1);
   assign col_next = FW_W'(col_ff) + FW_W'(1);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         grad_type tl, ml, bl, tc, bc, tr, mr, br;
         tl = lz_ff ? '0 : grad_type'({3'b0, win_ff[0][8*k +: 8]});
         ml = lz_ff ? '0 : grad_type'({3'b0, win_ff[1][8*k +: 8]});
         bl = lz_ff ? '0 : grad_type'({3'b0, win_ff[2][8*k +: 8]});
         tc = grad_type'({3'b0, win_ff[3][8*k +: 8]});
         bc = grad_type'({3'b0, win_ff[5][8*k +: 8]});
         tr = rz_ff ? '0 : grad_type'({3'b0, win_ff[6][8*k +: 8]});
         mr = rz_ff ? '0 : grad_type'({3'b0, win_ff[7][8*k +: 8]});
         br = rz_ff ? '0 : grad_type'({3'b0, win_ff[8][8*k +: 8]});
         gx_in[k] = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
         gy_in[k] = (bl - tl) + ((bc - tc) <<< 1) + (br - tr);
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [2*GRAD_W-1:0] sqx, sqy, sq;
         sqx = gx_ff[k] * gx_ff[k];
         sqy = gy_ff[k] * gy_ff[k];
         sq  = sqx + sqy;
         sum_in[k] = sq[SUM_W-1:0];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_root
      sem_root u_root (
         .clock, .reset, .start(state_ff == S_SQR), .value(sum_in[k]),
         .done(root_done[k]), .result(root_res[k])
      );
   end

   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (take) begin
                  px_ff    <= drain ? '0 : {req_chan.in_blue, req_chan.in_green, req_chan.in_red};
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               for (int i = 0; i < 6; i++) win_ff[i] <= win_ff[i+3];
               win_ff[6] <= top;
               win_ff[7] <= mid;
               win_ff[8] <= px_ff;
               last_ff   <= last;
               lz_ff     <= (col_ff != '0) ? (col_ff < COL_W'(2)) : (w_eff < FW_W'(2));
               rz_ff     <= (col_ff == '0);
               if (last) begin
                  row_ff <= '0;
                  col_ff <= '0;
               end else if (col_next >= w_eff) begin
                  col_ff <= '0;
                  row_ff <= row_ff + ROW_W'(1);
               end else begin
                  col_ff <= col_next[COL_W-1:0];
               end
               state_ff <= opv ? S_GRAD : S_IDLE;
            end
            S_GRAD: begin
               for (int k = 0; k < 3; k++) begin
                  gx_ff[k] <= gx_in[k];
                  gy_ff[k] <= gy_in[k];
               end
               if (last_ff) begin
                  for (int i = 0; i < 9; i++) win_ff[i] <= '0;
               end
               state_ff <= S_SQR;
            end
            S_SQR: begin
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               if (root_done[0]) state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_r_ff     <= root_res[0];
                  rsp_g_ff     <= root_res[1];
                  rsp_b_ff     <= root_res[2];
                  rsp_end_ff   <= last_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.edge_red   = rsp_r_ff;
   assign rsp_chan.edge_green = rsp_g_ff;
   assign rsp_chan.edge_blue  = rsp_b_ff;
   assign rsp_chan.frame_end  = rsp_end_ff;

   a_read_next: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |=> (state_ff == S_GRAD || state_ff == S_IDLE))
      else $error("bad state after line store read");
   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && last_ff) |-> (row_ff == '0 && col_ff == '0))
      else $error("position not back at frame start on frame end");
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      root_done[0] |-> (root_done[1] && root_done[2]))
      else $error("root lanes out of step");
endmodule

>>> hdl/sem_ram.sv
// Generic simple dual-port RAM with registered read.
module sem_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> hdl/sem_csr.sv
// APB register file holding frame width and frame height.
module sem_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [sem_pkg::ADDR_W-1:0] paddr,
   input  logic [sem_pkg::DATA_W-1:0] pwdata,
   output logic [sem_pkg::DATA_W-1:0] prdata,
   output logic                  pready,
   output logic [sem_pkg::FW_W-1:0]   frame_width,
   output logic [sem_pkg::FH_W-1:0]   frame_height
);
   import sem_pkg::*;

   logic [FW_W-1:0] width_ff;
   logic [FH_W-1:0] height_ff;
   reg_index_type   index;
   logic            wr;

   assign index  = reg_index_type'(paddr[2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= FW_W'(MAX_WIDTH);
         height_ff <= FH_W'(1);
      end else if (wr) begin
         case (index)
            REG_FRAME_WIDTH:  width_ff  <= pwdata[FW_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= pwdata[FH_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FRAME_WIDTH:  prdata = DATA_W'(width_ff);
         REG_FRAME_HEIGHT: prdata = DATA_W'(height_ff);
         default:          prdata = '0;
      endcase
   end

   assign frame_width  = width_ff;
   assign frame_height = height_ff;
endmodule

>>> hdl/sem_root.sv
// Bit-serial rounded square root, saturated to eight bits, one result bit per cycle.
module sem_root (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  sem_pkg::sum_type  value,
   output logic              done,
   output sem_pkg::chan_type result
);
   import sem_pkg::*;

   sum_type           val_ff;
   chan_type          res_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;
   chan_type          trial;
   logic [2*CHAN_W-1:0] prod;

   // largest t with t*(t-1) < value is round-to-nearest sqrt
   assign trial = res_ff | (CHAN_W'(1) << step_ff);
   assign prod  = trial * (trial - CHAN_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= STEP_W'(CHAN_W - 1);
            res_ff  <= '0;
            val_ff  <= value;
         end else if (run_ff) begin
            if (SUM_W'(prod) < val_ff) begin
               res_ff <= trial;
            end
            step_ff <= step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

   a_start_runs: assert property (@(posedge clock) disable iff (reset) start |=> run_ff)
      else $error("root search did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset) done_ff |-> !run_ff)
      else $error("root done while still running");
   a_last_step: assert property (@(posedge clock) disable iff (reset)
      (run_ff && !start && step_ff == '0) |=> done_ff)
      else $error("root search missed its final step");
endmodule

>>> verif/sem_tb_ifs.sv
// Testbench-side note: stream interfaces come from the design's interface file.
`timescale 1ns / 100ps
package sem_tb_pkg;
   import sem_pkg::*;

   typedef struct packed {
      logic     mode;
      chan_type red;
      chan_type green;
      chan_type blue;
   } pixel_item_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
      logic     frame_end;
   } edge_result_type;

   localparam logic MODE_DRAIN = 1'b1;
endpackage

>>> verif/tb_sobel_edge_magnitude_rgb.sv
// Self-checking testbench for the RGB Sobel edge magnitude block.
`timescale 1ns / 100ps
module tb_sobel_edge_magnitude_rgb;
   import sem_pkg::*;
   import sem_tb_pkg::*;

   logic clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   sem_req_if req_chan ();
   sem_rsp_if rsp_chan ();

   sobel_edge_magnitude_rgb dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pixel_item_type  pending_pixels[$];
   edge_result_type expected_edges[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int long_hold_req = 0;
   int hold_left = 0;

   // predictor state
   logic [10:0] width_reg = 11'd1024;
   logic [15:0] height_reg = 16'd1;
   pixel_type line_upper[MAX_WIDTH];
   pixel_type line_middle[MAX_WIDTH];
   pixel_type win[9];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   function automatic int unsigned eff_width();
      int unsigned w;
      w = (width_reg == 0) ? 1 : width_reg;
      return (w > MAX_WIDTH) ? MAX_WIDTH : w;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic chan_type channel_magnitude(pixel_type lft[3], pixel_type rgt[3], int k);
      int tl, ml, bl, tc, bc, tr, mr, br, gx, gy, s, n, t;
      tl = lft[0][8*k+:8]; ml = lft[1][8*k+:8]; bl = lft[2][8*k+:8];
      tc = win[3][8*k+:8]; bc = win[5][8*k+:8];
      tr = rgt[0][8*k+:8]; mr = rgt[1][8*k+:8]; br = rgt[2][8*k+:8];
      gx = (tr - tl) + 2 * (mr - ml) + (br - bl);
      gy = (bl - tl) + 2 * (bc - tc) + (br - tr);
      s = gx * gx + gy * gy;
      n = 0;
      for (int b = 11; b >= 0; b--) begin
         t = n | (1 << b);
         if (t * t <= s) n = t;
      end
      if (s - n * n > n) n++;
      return (n > 255) ? 8'd255 : n[7:0];
   endfunction

   function automatic void predict_edges(pixel_item_type it);
      int unsigned w, h, r, c;
      logic drain, valid_pos, last;
      pixel_type px, top, mid;
      pixel_type lft[3], rgt[3];
      edge_result_type res;
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = (col_pos >= MAX_WIDTH) ? 0 : col_pos;
      drain = (r >= h);
      if (!drain && it.mode == MODE_DRAIN) return;
      px = drain ? '0 : {it.blue, it.green, it.red};
      top = line_upper[c];
      mid = line_middle[c];
      line_upper[c] = mid;
      line_middle[c] = px;
      if (!(r >= 2 && r - 2 < h)) top = '0;
      if (!(r >= 1 && r - 1 < h)) mid = '0;
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top; win[7] = mid; win[8] = px;
      valid_pos = (r >= 2) || (r == 1 && c >= 1);
      last = (r >= h + 1);
      if (valid_pos) begin
         for (int i = 0; i < 3; i++) begin
            lft[i] = ((c >= 2) || (c == 0 && w >= 2)) ? win[i] : '0;
            rgt[i] = (c >= 1) ? win[6+i] : '0;
         end
         res.red = channel_magnitude(lft, rgt, 0);
         res.green = channel_magnitude(lft, rgt, 1);
         res.blue = channel_magnitude(lft, rgt, 2);
         res.frame_end = last;
         expected_edges.push_back(res);
      end
      if (last) begin
         row_pos = 0;
         col_pos = 0;
         for (int i = 0; i < 9; i++) win[i] = '0;
      end else begin
         c++;
         if (c >= w) begin
            c = 0;
            r++;
         end
         col_pos = c;
         row_pos = r;
      end
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("FAILURE");
      $finish;
   end

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_edges({req_chan.mode, req_chan.in_red, req_chan.in_green, req_chan.in_blue});
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               pixel_item_type it;
               it = pending_pixels.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.mode <= it.mode;
               req_chan.in_red <= it.red;
               req_chan.in_green <= it.green;
               req_chan.in_blue <= it.blue;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result ready, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (long_hold_req > 0) begin
         hold_left = long_hold_req;
         long_hold_req = 0;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         edge_result_type got, want;
         got = {rsp_chan.edge_red, rsp_chan.edge_green, rsp_chan.edge_blue, rsp_chan.frame_end};
         if (expected_edges.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_edges.pop_front();
            if (got !== want) begin
               $display("%0t: edge mismatch, expected r=%0d g=%0d b=%0d end=%0b, actual r=%0d g=%0d b=%0d end=%0b",
                        $time, want.red, want.green, want.blue, want.frame_end,
                        got.red, got.green, got.blue, got.frame_end);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [DATA_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == REG_FRAME_WIDTH) width_reg = value[10:0];
      else height_reg = value[15:0];
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_pixels.size() > 0 || req_chan.valid || expected_edges.size() > 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic chan_type rand_chan();
      case ($urandom_range(3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // one full frame at the current settings; noise adds ignored and discarded items
   task automatic push_frame(int noise_pct);
      pixel_item_type it;
      int unsigned n;
      n = eff_width() * eff_height();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct) begin
            it = {MODE_DRAIN, rand_chan(), rand_chan(), rand_chan()};
            pending_pixels.push_back(it);
         end
         it = {MODE_PIXEL, rand_chan(), rand_chan(), rand_chan()};
         pending_pixels.push_back(it);
      end
      for (int i = 0; i <= eff_width(); i++) begin
         it = {($urandom_range(99) < noise_pct) ? MODE_PIXEL : MODE_DRAIN,
               rand_chan(), rand_chan(), rand_chan()};
         pending_pixels.push_back(it);
      end
   endtask

   task automatic run_frames(int target);
      int sent;
      sent = 0;
      while (sent < target) begin
         csr_write(REG_FRAME_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(32, 12)
                                                             : $urandom_range(8, 0));
         csr_write(REG_FRAME_HEIGHT, $urandom_range(6, 0));
         push_frame(15);
         sent += eff_width() * (eff_height() + 1) + 1;
         wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_chan.valid = 1'b0; req_chan.mode = MODE_PIXEL;
      req_chan.in_red = '0; req_chan.in_green = '0; req_chan.in_blue = '0;
      rsp_chan.ready = 1'b0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_upper[i] = '0;
         line_middle[i] = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: small frame with extremes, width and height out of range
      csr_write(REG_FRAME_WIDTH, 3);
      csr_write(REG_FRAME_HEIGHT, 2);
      pending_pixels.push_back({MODE_PIXEL, 8'd255, 8'd0, 8'd255});
      pending_pixels.push_back({MODE_DRAIN, 8'd255, 8'd255, 8'd255});
      pending_pixels.push_back({MODE_PIXEL, 8'd0, 8'd255, 8'd0});
      pending_pixels.push_back({MODE_PIXEL, 8'd255, 8'd0, 8'd255});
      pending_pixels.push_back({MODE_PIXEL, 8'd0, 8'd0, 8'd0});
      pending_pixels.push_back({MODE_PIXEL, 8'd255, 8'd255, 8'd255});
      pending_pixels.push_back({MODE_PIXEL, 8'd0, 8'd0, 8'd0});
      pending_pixels.push_back({MODE_DRAIN, 8'd0, 8'd0, 8'd0});
      pending_pixels.push_back({MODE_PIXEL, 8'd255, 8'd255, 8'd255});
      pending_pixels.push_back({MODE_DRAIN, 8'd0, 8'd0, 8'd0});
      pending_pixels.push_back({MODE_DRAIN, 8'd0, 8'd0, 8'd0});
      wait_drained();
      csr_write(REG_FRAME_WIDTH, 0);
      csr_write(REG_FRAME_HEIGHT, 0);
      push_frame(0);
      wait_drained();

      // random phases; the first also holds the result side off for a long stretch
      send_idle_pct = 0; recv_stall_pct = 0;
      csr_write(REG_FRAME_WIDTH, 6);
      csr_write(REG_FRAME_HEIGHT, 5);
      long_hold_req = 400;
      push_frame(10);
      wait_drained();
      run_frames(160);
      send_idle_pct = 68; recv_stall_pct = 0;
      run_frames(190);
      send_idle_pct = 0; recv_stall_pct = 68;
      run_frames(190);
      send_idle_pct = 28; recv_stall_pct = 28;
      run_frames(190);
      wait_drained();

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> sobel_edge_magnitude_rgb.f
hdl/sem_pkg.sv
hdl/sem_ifs.sv
hdl/sem_ram.sv
hdl/sem_csr.sv
hdl/sem_root.sv
hdl/sobel_edge_magnitude_rgb.sv
verif/sem_tb_ifs.sv
verif/tb_sobel_edge_magnitude_rgb.sv
